FILE: hw/rtl/base_n_digits_to_bytes_unit_defines.svh
// Assertion macros for the base-N digits to bytes unit.
// Used by base_n_digits_to_bytes_unit.sv; no other dependencies.
`ifndef BASE_N_DIGITS_TO_BYTES_UNIT_DEFINES_SVH
`define BASE_N_DIGITS_TO_BYTES_UNIT_DEFINES_SVH

// same-cycle implication
`define BND_ASSERT_IMPLY(lbl, clk, rst, ante, cons, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error(msg);

// next-cycle implication
`define BND_ASSERT_NEXT(lbl, clk, rst, ante, cons, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error(msg);

`endif

FILE: hw/rtl/bnd_pkg.sv
// Package for the base-N digits to bytes unit: widths, register indexes,
// status codes and the item types. No dependencies.
package bnd_pkg;

   localparam int DEF_MAX_BYTES   = 32;
   localparam int DEF_MAX_SYMBOLS = 32;
   localparam int RESULT_LIMIT    = 32;

   localparam int BYTE_W          = 8;
   localparam int SYMBOL_W        = 8;
   localparam int BASE_W          = 6;
   localparam int OUT_BYTES_W     = 6;
   localparam int ALPHA_WORDS     = 4;
   localparam int ALPHA_WORD_W    = 64;
   localparam int ALPHA_W         = ALPHA_WORDS * ALPHA_WORD_W;
   localparam int DIGIT_W         = 5;
   localparam int CARRY_W         = 6;
   localparam int SUM_W           = 14;
   localparam int BYTE_INDEX_W    = 5;
   localparam int CSR_IDX_W       = 3;
   localparam int CSR_DATA_W      = 64;

   localparam logic [BASE_W-1:0]      RESET_BASE      = 6'd24;
   localparam logic [OUT_BYTES_W-1:0] RESET_OUT_BYTES = 6'd15;

   typedef enum logic [CSR_IDX_W-1:0] {
      CSR_BASE      = 3'd0,
      CSR_ALPHA_0   = 3'd1,
      CSR_ALPHA_1   = 3'd2,
      CSR_ALPHA_2   = 3'd3,
      CSR_ALPHA_3   = 3'd4,
      CSR_OUT_BYTES = 3'd5
   } bnd_csr_type;

   typedef enum logic [1:0] {
      STATUS_OK         = 2'd0,
      STATUS_BAD_SYMBOL = 2'd1,
      STATUS_OVERFLOW   = 2'd2
   } bnd_status_type;

   typedef struct packed {
      logic [SYMBOL_W-1:0] symbol;
      logic                end_of_text;
   } bnd_req_type;

   typedef struct packed {
      logic [BYTE_W-1:0]       value_byte;
      logic [BYTE_INDEX_W-1:0] byte_index;
      bnd_status_type          status;
      logic                    last_byte;
   } bnd_rsp_type;

   typedef struct packed {
      logic               found;
      logic [DIGIT_W-1:0] digit;
   } bnd_lookup_type;

endpackage

FILE: hw/rtl/bnd_stream_if.sv
// Valid/ready channel interfaces for the request and response items.
// Depends on bnd_pkg.
interface bnd_req_if;
   logic                  valid;
   logic                  ready;
   bnd_pkg::bnd_req_type  payload;

   modport source (output valid, output payload, input ready);
   modport sink   (input valid, input payload, output ready);
endinterface

interface bnd_rsp_if;
   logic                  valid;
   logic                  ready;
   bnd_pkg::bnd_rsp_type  payload;

   modport source (output valid, output payload, input ready);
   modport sink   (input valid, input payload, output ready);
endinterface

FILE: hw/rtl/bnd_digit_lookup.sv
// Alphabet search: first alphabet position whose code equals the symbol.
// Depends on bnd_pkg.
module bnd_digit_lookup #(
   parameter int MAX_SYMBOLS = bnd_pkg::DEF_MAX_SYMBOLS
) (
   input  logic [bnd_pkg::SYMBOL_W-1:0] symbol,
   input  logic [bnd_pkg::BASE_W-1:0]   base,
   input  logic [bnd_pkg::ALPHA_W-1:0]  alphabet,
   output bnd_pkg::bnd_lookup_type      result
);

   localparam int BW = bnd_pkg::BASE_W;
   localparam int DW = bnd_pkg::DIGIT_W;
   localparam int SW = bnd_pkg::SYMBOL_W;

   // scan from the top so the lowest match wins
   always_comb begin
      result = '0;
      for (int k = MAX_SYMBOLS - 1; k >= 0; k--) begin
         if (((BW)'(k) < base) && (alphabet[k*SW +: SW] == symbol)) begin
            result.found = 1'b1;
            result.digit = (DW)'(k);
         end
      end
   end

endmodule

FILE: hw/rtl/base_n_digits_to_bytes_unit.sv
// Base-N text to little-endian binary converter, top level.
// Depends on bnd_pkg, bnd_stream_if, bnd_digit_lookup and the defines header.
//
// Usage:
//   req_ch carries one symbol per item, most significant first; end_of_text
//   marks the last one. rsp_ch carries the result bytes, least significant
//   first, or one error item (value 0, index 0, last_byte set).
//   csr_* writes base, the four alphabet words and out_bytes; write only
//   while the block is idle.
// Timing:
//   The value lives in a byte memory with one write and one registered read.
//   Each symbol makes a memory pass over the bytes in use, one byte per
//   cycle, then a carry step; an ignored symbol after an error makes no pass.
//   After the last symbol, a check step, then one result byte per cycle
//   while rsp_ch does not stall.
// Reset: synchronous; restores the register defaults and empties the value;
//   entries beyond the fill count read as zero, so no clearing pass is run.
// Stalls: results sit in an output register; a stalled rsp_ch holds it and
//   the byte pass waits. The next string's first symbol is taken while the
//   final result still waits.
`include "base_n_digits_to_bytes_unit_defines.svh"

module base_n_digits_to_bytes_unit #(
   parameter int MAX_BYTES   = bnd_pkg::DEF_MAX_BYTES,
   parameter int MAX_SYMBOLS = bnd_pkg::DEF_MAX_SYMBOLS
) (
   input  logic                           clock,
   input  logic                           reset,
   bnd_req_if.sink                        req_ch,
   bnd_rsp_if.source                      rsp_ch,
   input  logic                           csr_we,
   input  logic [bnd_pkg::CSR_IDX_W-1:0]  csr_index,
   input  logic [bnd_pkg::CSR_DATA_W-1:0] csr_wdata
);

   localparam int IDX_W   = (MAX_BYTES > 1) ? $clog2(MAX_BYTES) : 1;
   localparam int CNT_W   = $clog2(MAX_BYTES + 1);
   localparam int CMP_W   = (CNT_W > bnd_pkg::OUT_BYTES_W) ? CNT_W : bnd_pkg::OUT_BYTES_W;
   localparam int BYTE_W  = bnd_pkg::BYTE_W;
   localparam int SUM_W   = bnd_pkg::SUM_W;
   localparam int CARRY_W = bnd_pkg::CARRY_W;
   localparam int BI_W    = bnd_pkg::BYTE_INDEX_W;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_MAC,
      ST_CARRY,
      ST_END,
      ST_LD,
      ST_ERR
   } state_type;

   // configuration
   logic [bnd_pkg::BASE_W-1:0]                                 base_ff;
   logic [bnd_pkg::OUT_BYTES_W-1:0]                            out_bytes_ff;
   logic [bnd_pkg::ALPHA_WORDS-1:0][bnd_pkg::ALPHA_WORD_W-1:0] alpha_ff;

   // value memory
   logic [BYTE_W-1:0] mem [MAX_BYTES];
   logic [BYTE_W-1:0] rd_data_ff;
   logic [IDX_W-1:0]  rd_addr;
   logic              mem_we;
   logic [IDX_W-1:0]  mem_waddr;
   logic [BYTE_W-1:0] mem_wdata;

   // control
   state_type               state_ff, state_in;
   logic [CNT_W-1:0]        count_ff, count_in;
   bnd_pkg::bnd_status_type err_ff, err_in;
   logic                    nz_valid_ff, nz_valid_in;
   logic [IDX_W-1:0]        nz_top_ff, nz_top_in;
   logic [IDX_W-1:0]        idx_ff, idx_in;
   logic [CARRY_W-1:0]      carry_ff, carry_in;
   logic                    last_ff, last_in;
   logic                    rsp_valid_ff, rsp_valid_in;
   bnd_pkg::bnd_rsp_type    rsp_ff, rsp_in;

   logic                    req_ready;
   logic                    req_take;
   logic                    out_free;
   logic [IDX_W-1:0]        top_idx;
   logic [BYTE_W-1:0]       cur_byte;
   logic [SUM_W-1:0]        mac_sum;
   logic [CMP_W-1:0]        eff_raw;
   logic [CMP_W-1:0]        eff;
   bnd_pkg::bnd_lookup_type lookup;

   bnd_digit_lookup #(
      .MAX_SYMBOLS (MAX_SYMBOLS)
   ) u_lookup (
      .symbol   (req_ch.payload.symbol),
      .base     (base_ff),
      .alphabet (alpha_ff),
      .result   (lookup)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         base_ff      <= bnd_pkg::RESET_BASE;
         out_bytes_ff <= bnd_pkg::RESET_OUT_BYTES;
         alpha_ff     <= '0;
      end else if (csr_we) begin
         unique case (csr_index)
            bnd_pkg::CSR_BASE:      base_ff <= csr_wdata[bnd_pkg::BASE_W-1:0];
            bnd_pkg::CSR_ALPHA_0:   alpha_ff[0] <= csr_wdata;
            bnd_pkg::CSR_ALPHA_1:   alpha_ff[1] <= csr_wdata;
            bnd_pkg::CSR_ALPHA_2:   alpha_ff[2] <= csr_wdata;
            bnd_pkg::CSR_ALPHA_3:   alpha_ff[3] <= csr_wdata;
            bnd_pkg::CSR_OUT_BYTES: out_bytes_ff <= csr_wdata[bnd_pkg::OUT_BYTES_W-1:0];
            default: begin
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (mem_we) begin
         mem[mem_waddr] <= mem_wdata;
      end
      rd_data_ff <= mem[rd_addr];
   end

   assign req_ready = (state_ff == ST_IDLE);
   assign req_take  = req_ready && req_ch.valid;
   assign out_free  = !rsp_valid_ff || rsp_ch.ready;
   assign top_idx   = (count_ff == '0) ? '0 : IDX_W'(count_ff - 1'b1);
   // entries at or above the fill count read as zero
   assign cur_byte  = (CNT_W'(idx_ff) < count_ff) ? rd_data_ff : '0;
   assign mac_sum   = SUM_W'(carry_ff) + SUM_W'(cur_byte) * SUM_W'(base_ff);

   always_comb begin
      eff_raw = (out_bytes_ff == '0) ? CMP_W'(1) : CMP_W'(out_bytes_ff);
      eff     = eff_raw;
      if (eff > CMP_W'(MAX_BYTES)) begin
         eff = CMP_W'(MAX_BYTES);
      end
      if (eff > CMP_W'(bnd_pkg::RESULT_LIMIT)) begin
         eff = CMP_W'(bnd_pkg::RESULT_LIMIT);
      end
   end

   always_comb begin
      state_in     = state_ff;
      count_in     = count_ff;
      err_in       = err_ff;
      nz_valid_in  = nz_valid_ff;
      nz_top_in    = nz_top_ff;
      idx_in       = idx_ff;
      carry_in     = carry_ff;
      last_in      = last_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_ch.ready;
      rsp_in       = rsp_ff;
      rd_addr      = idx_ff;
      mem_we       = 1'b0;
      mem_waddr    = idx_ff;
      mem_wdata    = mac_sum[BYTE_W-1:0];

      unique case (state_ff)
         ST_IDLE: begin
            rd_addr = '0;
            if (req_take) begin
               last_in  = req_ch.payload.end_of_text;
               idx_in   = '0;
               carry_in = CARRY_W'(lookup.digit);
               if (err_ff != bnd_pkg::STATUS_OK) begin
                  state_in = req_ch.payload.end_of_text ? ST_END : ST_IDLE;
               end else if (!lookup.found) begin
                  err_in   = bnd_pkg::STATUS_BAD_SYMBOL;
                  state_in = req_ch.payload.end_of_text ? ST_END : ST_IDLE;
               end else begin
                  nz_valid_in = 1'b0;
                  state_in    = ST_MAC;
               end
            end
         end
         ST_MAC: begin
            mem_we   = 1'b1;
            carry_in = mac_sum[SUM_W-1 -: CARRY_W];
            if (mac_sum[BYTE_W-1:0] != '0) begin
               nz_valid_in = 1'b1;
               nz_top_in   = idx_ff;
            end
            if (idx_ff == top_idx) begin
               count_in = CNT_W'(idx_ff) + 1'b1;
               state_in = ST_CARRY;
            end else begin
               idx_in  = idx_ff + 1'b1;
               rd_addr = idx_ff + 1'b1;
            end
         end
         ST_CARRY: begin
            if (carry_ff != '0) begin
               if (idx_ff != IDX_W'(MAX_BYTES - 1)) begin
                  mem_we      = 1'b1;
                  mem_waddr   = idx_ff + 1'b1;
                  mem_wdata   = BYTE_W'(carry_ff);
                  count_in    = CNT_W'(idx_ff) + CNT_W'(2);
                  nz_valid_in = 1'b1;
                  nz_top_in   = idx_ff + 1'b1;
               end else begin
                  err_in = bnd_pkg::STATUS_OVERFLOW;
               end
            end
            state_in = last_ff ? ST_END : ST_IDLE;
         end
         ST_END: begin
            rd_addr = '0;
            idx_in  = '0;
            if (err_ff != bnd_pkg::STATUS_OK) begin
               state_in = ST_ERR;
            end else if (nz_valid_ff && (CMP_W'(nz_top_ff) >= eff)) begin
               err_in   = bnd_pkg::STATUS_OVERFLOW;
               state_in = ST_ERR;
            end else begin
               state_in = ST_LD;
            end
         end
         ST_LD: begin
            if (out_free) begin
               rsp_valid_in      = 1'b1;
               rsp_in.value_byte = cur_byte;
               rsp_in.byte_index = BI_W'(idx_ff);
               rsp_in.status     = bnd_pkg::STATUS_OK;
               rsp_in.last_byte  = (CMP_W'(idx_ff) + 1'b1 == eff);
               if (rsp_in.last_byte) begin
                  count_in    = '0;
                  nz_valid_in = 1'b0;
                  err_in      = bnd_pkg::STATUS_OK;
                  state_in    = ST_IDLE;
               end else begin
                  idx_in  = idx_ff + 1'b1;
                  rd_addr = idx_ff + 1'b1;
               end
            end
         end
         ST_ERR: begin
            if (out_free) begin
               rsp_valid_in      = 1'b1;
               rsp_in.value_byte = '0;
               rsp_in.byte_index = '0;
               rsp_in.status     = err_ff;
               rsp_in.last_byte  = 1'b1;
               count_in          = '0;
               nz_valid_in       = 1'b0;
               err_in            = bnd_pkg::STATUS_OK;
               state_in          = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         count_ff     <= '0;
         err_ff       <= bnd_pkg::STATUS_OK;
         nz_valid_ff  <= 1'b0;
         nz_top_ff    <= '0;
         idx_ff       <= '0;
         carry_ff     <= '0;
         last_ff      <= 1'b0;
         rsp_valid_ff <= 1'b0;
         rsp_ff       <= '0;
      end else begin
         state_ff     <= state_in;
         count_ff     <= count_in;
         err_ff       <= err_in;
         nz_valid_ff  <= nz_valid_in;
         nz_top_ff    <= nz_top_in;
         idx_ff       <= idx_in;
         carry_ff     <= carry_in;
         last_ff      <= last_in;
         rsp_valid_ff <= rsp_valid_in;
         rsp_ff       <= rsp_in;
      end
   end

   assign req_ch.ready   = req_ready;
   assign rsp_ch.valid   = rsp_valid_ff;
   assign rsp_ch.payload = rsp_ff;

   `BND_ASSERT_IMPLY(a_fill_bound, clock, reset, 1'b1, count_ff <= CNT_W'(MAX_BYTES), "fill count past store")
   `BND_ASSERT_IMPLY(a_mac_in_use, clock, reset, state_ff == ST_MAC, idx_ff <= top_idx, "byte pass beyond top byte")
   `BND_ASSERT_IMPLY(a_err_item, clock, reset, rsp_valid_ff && (rsp_ff.status != bnd_pkg::STATUS_OK), rsp_ff.last_byte && (rsp_ff.value_byte == '0), "error item not final or nonzero")
   `BND_ASSERT_NEXT(a_clear_after_last, clock, reset, (state_ff == ST_LD) && out_free && rsp_in.last_byte, (count_ff == '0) && (err_ff == bnd_pkg::STATUS_OK), "store not cleared after string")

endmodule

FILE: verif/testbench.sv
// Self-checking testbench for base_n_digits_to_bytes_unit: symbol strings in, result bytes out.
// Predicts each result from its own copy of the value store and registers.
// Depends on bnd_pkg, bnd_stream_if and base_n_digits_to_bytes_unit.
module testbench;
   timeunit 1ns;
   timeprecision 1ps;

   localparam int STORE_BYTES   = bnd_pkg::DEF_MAX_BYTES;
   localparam int SETTLE_CYCLES = bnd_pkg::DEF_MAX_BYTES + 8;
   localparam int TIMEOUT_NS    = 5_000_000;
   localparam int IDX_W         = bnd_pkg::CSR_IDX_W;
   localparam int BI_W          = bnd_pkg::BYTE_INDEX_W;
   localparam logic [IDX_W-1:0] CSR_SPARE_6 = 3'd6;
   localparam logic [IDX_W-1:0] CSR_SPARE_7 = 3'd7;

   typedef enum int {RX_ALWAYS, RX_RANDOM, RX_PERIODIC} rx_mode_type;

   logic clock = 1'b0;
   logic reset;
   logic csr_we;
   logic [IDX_W-1:0] csr_index;
   logic [bnd_pkg::CSR_DATA_W-1:0] csr_wdata;

   bnd_req_if req_ch ();
   bnd_rsp_if rsp_ch ();

   base_n_digits_to_bytes_unit DUT (
      .clock     (clock),
      .reset     (reset),
      .req_ch    (req_ch),
      .rsp_ch    (rsp_ch),
      .csr_we    (csr_we),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata)
   );

   always #5 clock = ~clock;

   // predicted block state
   logic [bnd_pkg::BYTE_W-1:0]       value_store [STORE_BYTES];
   int unsigned                      value_top;
   bnd_pkg::bnd_status_type          string_error;
   logic [bnd_pkg::BASE_W-1:0]       cfg_radix;
   logic [bnd_pkg::ALPHA_WORD_W-1:0] cfg_alphabet [bnd_pkg::ALPHA_WORDS];
   logic [bnd_pkg::OUT_BYTES_W-1:0]  cfg_out_bytes;
   bnd_pkg::bnd_rsp_type             expected_bytes [$];

   int          fail_count = 0;
   rx_mode_type rx_mode;
   int          rx_tick = 0;
   int          hold_left;
   int          gap_max;
   int          burst_left;

   function automatic void clear_string();
      foreach (value_store[i]) value_store[i] = '0;
      value_top = 0;
      string_error = bnd_pkg::STATUS_OK;
   endfunction

   function automatic int unsigned search_count();
      return (cfg_radix > bnd_pkg::DEF_MAX_SYMBOLS) ? bnd_pkg::DEF_MAX_SYMBOLS : cfg_radix;
   endfunction

   function automatic logic [7:0] alphabet_symbol(input int unsigned pos);
      return cfg_alphabet[pos / 8][(pos % 8) * 8 +: 8];
   endfunction

   function automatic bit digit_of(input logic [7:0] sym, output int unsigned digit);
      digit = 0;
      for (int unsigned k = 0; k < search_count(); k++) begin
         if (alphabet_symbol(k) == sym) begin
            digit = k;
            return 1'b1;
         end
      end
      return 1'b0;
   endfunction

   function automatic logic [7:0] absent_symbol();
      int unsigned digit;
      logic [7:0] sym;
      sym = 8'($urandom);
      while (digit_of(sym, digit)) sym++;
      return sym;
   endfunction

   function automatic void multiply_add(input int unsigned digit);
      int unsigned carry;
      carry = digit;
      for (int unsigned i = 0; i <= value_top; i++) begin
         carry = carry + 32'(value_store[i]) * 32'(cfg_radix);
         value_store[i] = 8'(carry);
         carry = carry >> 8;
      end
      if (carry != 0) begin
         if (value_top + 1 < STORE_BYTES) begin
            value_top++;
            value_store[value_top] = 8'(carry);
         end else if (string_error == bnd_pkg::STATUS_OK) begin
            string_error = bnd_pkg::STATUS_OVERFLOW;
         end
      end
   endfunction

   function automatic void predict_item(input bnd_pkg::bnd_req_type item);
      int unsigned digit;
      int unsigned count;
      bnd_pkg::bnd_rsp_type rsp;
      if (string_error == bnd_pkg::STATUS_OK) begin
         if (digit_of(item.symbol, digit)) multiply_add(digit);
         else string_error = bnd_pkg::STATUS_BAD_SYMBOL;
      end
      if (!item.end_of_text) return;
      count = (cfg_out_bytes == 0) ? 1 : cfg_out_bytes;
      if (count > STORE_BYTES) count = STORE_BYTES;
      if (count > bnd_pkg::RESULT_LIMIT) count = bnd_pkg::RESULT_LIMIT;
      if (string_error == bnd_pkg::STATUS_OK) begin
         for (int unsigned i = count; i < STORE_BYTES; i++)
            if (value_store[i] != 0) string_error = bnd_pkg::STATUS_OVERFLOW;
      end
      if (string_error != bnd_pkg::STATUS_OK) begin
         rsp.value_byte = '0;
         rsp.byte_index = '0;
         rsp.status     = string_error;
         rsp.last_byte  = 1'b1;
         expected_bytes.push_back(rsp);
      end else begin
         for (int unsigned i = 0; i < count; i++) begin
            rsp.value_byte = value_store[i];
            rsp.byte_index = BI_W'(i);
            rsp.status     = bnd_pkg::STATUS_OK;
            rsp.last_byte  = (i + 1 == count);
            expected_bytes.push_back(rsp);
         end
      end
      clear_string();
   endfunction

   always @(posedge clock) begin : check_results
      bnd_pkg::bnd_rsp_type got;
      bnd_pkg::bnd_rsp_type want;
      if (!reset && rsp_ch.valid === 1'b1 && rsp_ch.ready === 1'b1) begin
         got = rsp_ch.payload;
         if (expected_bytes.size() == 0) begin
            $error("unexpected item: value_byte %0h byte_index %0d status %0d last_byte %0b",
                   got.value_byte, got.byte_index, got.status, got.last_byte);
            fail_count++;
         end else begin
            want = expected_bytes.pop_front();
            if (got.value_byte !== want.value_byte) begin
               $error("value_byte: expected %0h, got %0h", want.value_byte, got.value_byte);
               fail_count++;
            end
            if (got.byte_index !== want.byte_index) begin
               $error("byte_index: expected %0d, got %0d", want.byte_index, got.byte_index);
               fail_count++;
            end
            if (got.status !== want.status) begin
               $error("status: expected %0d, got %0d", want.status, got.status);
               fail_count++;
            end
            if (got.last_byte !== want.last_byte) begin
               $error("last_byte: expected %0b, got %0b", want.last_byte, got.last_byte);
               fail_count++;
            end
         end
      end
   end

   // result receiver: long hold-off when requested, else the current stall pattern
   always @(negedge clock) begin
      rx_tick++;
      if (hold_left > 0) begin
         hold_left--;
         rsp_ch.ready <= 1'b0;
      end else begin
         case (rx_mode)
            RX_ALWAYS: rsp_ch.ready <= 1'b1;
            RX_RANDOM: rsp_ch.ready <= ($urandom_range(0, 3) != 0);
            default:   rsp_ch.ready <= ((rx_tick % 7) < 4);
         endcase
      end
   end

   task automatic send_item(input logic [7:0] sym, input logic eot);
      bnd_pkg::bnd_req_type item;
      int unsigned gap;
      item.symbol = sym;
      item.end_of_text = eot;
      gap = 0;
      if (burst_left == 0) begin
         burst_left = $urandom_range(1, 12);
         if (gap_max != 0) gap = $urandom_range(0, gap_max);
      end
      burst_left--;
      @(negedge clock);
      if (gap != 0) begin
         req_ch.valid <= 1'b0;
         repeat (gap) @(negedge clock);
      end
      req_ch.valid <= 1'b1;
      req_ch.payload <= item;
      do @(posedge clock); while (req_ch.ready !== 1'b1);
      predict_item(item);
   endtask

   task automatic send_random_string(input int unsigned len, input int unsigned noise_pct);
      logic [7:0] sym;
      for (int unsigned p = 0; p < len; p++) begin
         if (search_count() == 0 || $urandom_range(0, 99) < noise_pct)
            sym = 8'($urandom);
         else
            sym = alphabet_symbol($urandom_range(0, search_count() - 1));
         send_item(sym, p + 1 == len);
      end
   endtask

   task automatic wait_idle();
      @(negedge clock);
      req_ch.valid <= 1'b0;
      while (expected_bytes.size() != 0) @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   task automatic write_reg(input logic [IDX_W-1:0] idx,
                            input logic [bnd_pkg::CSR_DATA_W-1:0] data);
      @(negedge clock);
      csr_we    <= 1'b1;
      csr_index <= idx;
      csr_wdata <= data;
      @(posedge clock);
      case (idx)
         bnd_pkg::CSR_BASE:      cfg_radix = data[bnd_pkg::BASE_W-1:0];
         bnd_pkg::CSR_ALPHA_0,
         bnd_pkg::CSR_ALPHA_1,
         bnd_pkg::CSR_ALPHA_2,
         bnd_pkg::CSR_ALPHA_3:   cfg_alphabet[idx - bnd_pkg::CSR_ALPHA_0] = data;
         bnd_pkg::CSR_OUT_BYTES: cfg_out_bytes = data[bnd_pkg::OUT_BYTES_W-1:0];
         default: ;
      endcase
      @(negedge clock);
      csr_we <= 1'b0;
   endtask

   task automatic set_sizes(input logic [bnd_pkg::BASE_W-1:0] radix,
                            input logic [bnd_pkg::OUT_BYTES_W-1:0] out_len);
      logic [bnd_pkg::CSR_DATA_W-1:0] data;
      data = {$urandom, $urandom};
      data[bnd_pkg::BASE_W-1:0] = radix;
      write_reg(bnd_pkg::CSR_BASE, data);
      data = {$urandom, $urandom};
      data[bnd_pkg::OUT_BYTES_W-1:0] = out_len;
      write_reg(bnd_pkg::CSR_OUT_BYTES, data);
   endtask

   // repeats draws every code from a dozen values, so most positions are shadowed
   task automatic set_alphabet(input bit repeats);
      logic [7:0] pool [256];
      logic [7:0] swap;
      logic [bnd_pkg::ALPHA_WORD_W-1:0] word;
      int unsigned j;
      for (int i = 0; i < 256; i++) pool[i] = 8'(i);
      for (int i = 255; i > 0; i--) begin
         j = $urandom_range(0, i);
         swap = pool[i];
         pool[i] = pool[j];
         pool[j] = swap;
      end
      for (int w = 0; w < bnd_pkg::ALPHA_WORDS; w++) begin
         for (int b = 0; b < 8; b++)
            word[b * 8 +: 8] = repeats ? pool[$urandom_range(0, 11)] : pool[w * 8 + b];
         write_reg(IDX_W'(bnd_pkg::CSR_ALPHA_0 + w), word);
      end
   endtask

   task automatic test_reset_values();
      send_item(8'h00, 1'b1);
      send_item(8'hFF, 1'b1);
   endtask

   task automatic test_digit_extremes();
      wait_idle();
      set_alphabet(1'b0);
      set_sizes(6'd32, 6'd32);
      send_item(alphabet_symbol(31), 1'b0);
      send_item(alphabet_symbol(31), 1'b1);
      send_item(alphabet_symbol(0), 1'b1);
      wait_idle();
      set_sizes(6'd32, 6'd1);
      send_item(alphabet_symbol(31), 1'b0);
      send_item(alphabet_symbol(31), 1'b1);
      send_item(alphabet_symbol(7), 1'b1);
      // bad symbol reported even though the value would not fit either
      send_item(alphabet_symbol(31), 1'b0);
      send_item(absent_symbol(), 1'b0);
      send_item(alphabet_symbol(31), 1'b0);
      send_item(alphabet_symbol(1), 1'b1);
      send_item(absent_symbol(), 1'b1);
   endtask

   task automatic test_radix_edges();
      wait_idle();
      set_sizes(6'd0, 6'd0);
      send_item(alphabet_symbol(0), 1'b1);
      wait_idle();
      set_sizes(6'd1, 6'd0);
      send_item(alphabet_symbol(0), 1'b0);
      send_item(alphabet_symbol(0), 1'b1);
      send_item(alphabet_symbol(1), 1'b1);
      wait_idle();
      set_sizes(6'd63, 6'd63);
      send_item(alphabet_symbol(31), 1'b0);
      send_item(alphabet_symbol(1), 1'b1);
   endtask

   task automatic test_shadowed_symbols();
      logic [bnd_pkg::ALPHA_WORD_W-1:0] word;
      wait_idle();
      set_sizes(6'd32, 6'd2);
      word = cfg_alphabet[2];
      word[4 * 8 +: 8] = alphabet_symbol(3);
      write_reg(bnd_pkg::CSR_ALPHA_2, word);
      send_item(alphabet_symbol(20), 1'b1);
      wait_idle();
      write_reg(CSR_SPARE_6, {$urandom, $urandom});
      write_reg(CSR_SPARE_7, {$urandom, $urandom});
      send_item(alphabet_symbol(5), 1'b0);
      send_item(alphabet_symbol(30), 1'b1);
   endtask

   task automatic test_random_strings();
      int unsigned sent;
      int unsigned len;
      for (int phase = 0; phase < 6; phase++) begin
         wait_idle();
         set_alphabet(phase == 3 || (phase == 5 && $urandom_range(0, 1) == 1));
         case (phase)
            0: set_sizes(6'd2, 6'd32);
            1: set_sizes(6'd32, 6'd1);
            2: set_sizes(6'd63, 6'd0);
            3: set_sizes(6'($urandom_range(3, 31)), 6'($urandom_range(1, 32)));
            4: set_sizes(6'd10, 6'd63);
            default: set_sizes(6'($urandom_range(0, 63)), 6'($urandom_range(0, 63)));
         endcase
         rx_mode = rx_mode_type'(phase % 3);
         gap_max = (phase % 2 == 1) ? 6 : 0;
         sent = 0;
         while (sent < 33) begin
            len = ($urandom_range(0, 9) == 0) ? $urandom_range(10, 24) : $urandom_range(1, 6);
            send_random_string(len, 5);
            sent += len;
         end
      end
   endtask

   task automatic test_long_strings();
      wait_idle();
      set_alphabet(1'b0);
      set_sizes(6'd63, 6'd32);
      rx_mode = RX_RANDOM;
      gap_max = 2;
      // carry leaves the top byte, later symbols are ignored
      for (int p = 0; p < 46; p++) send_item(alphabet_symbol(31), 1'b0);
      send_item(absent_symbol(), 1'b0);
      send_item(alphabet_symbol(5), 1'b1);
      wait_idle();
      set_sizes(6'd32, 6'd32);
      for (int p = 0; p < 40; p++) send_item(alphabet_symbol($urandom_range(0, 31)), p == 39);
   endtask

   task automatic test_output_stall();
      wait_idle();
      set_alphabet(1'b0);
      set_sizes(6'd10, 6'd4);
      rx_mode = RX_ALWAYS;
      gap_max = 0;
      hold_left = 400;
      for (int s = 0; s < 10; s++) send_random_string($urandom_range(2, 6), 0);
   endtask

   initial begin
      reset = 1'b1;
      req_ch.valid = 1'b0;
      req_ch.payload = '0;
      rsp_ch.ready = 1'b0;
      csr_we = 1'b0;
      csr_index = '0;
      csr_wdata = '0;
      rx_mode = RX_ALWAYS;
      hold_left = 0;
      gap_max = 0;
      burst_left = 0;
      cfg_radix = bnd_pkg::RESET_BASE;
      cfg_out_bytes = bnd_pkg::RESET_OUT_BYTES;
      foreach (cfg_alphabet[i]) cfg_alphabet[i] = '0;
      clear_string();
      repeat (9) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      test_reset_values();
      test_digit_extremes();
      test_radix_edges();
      test_shadowed_symbols();
      test_random_strings();
      test_long_strings();
      test_output_stall();

      wait_idle();
      if (fail_count == 0) begin
         $display("== PASS ==");
      end else begin
         $display("== FAIL ==");
      end
      $finish;
   end

   initial begin
      #(TIMEOUT_NS);
      $display("== FAIL ==");
      $finish;
   end

endmodule

FILE: filelist.f
+incdir+hw/rtl
hw/rtl/bnd_pkg.sv
hw/rtl/bnd_stream_if.sv
hw/rtl/bnd_digit_lookup.sv
hw/rtl/base_n_digits_to_bytes_unit.sv
verif/testbench.sv
